// ===== design/uce_pkg.sv =====
package uce_pkg;

  localparam int REPLY_DEPTH = 16;
  localparam int FILL_W      = $clog2(REPLY_DEPTH + 1);
  localparam int STORE_AW    = $clog2(REPLY_DEPTH);
  localparam int FRAME_LEN   = 8;
  localparam int IDX_W       = $clog2(FRAME_LEN + 1);

  localparam logic [7:0]        SYNC_BYTE    = 8'hFF;
  localparam logic [FILL_W-1:0] REPLY_NEEDED = FILL_W'(8);

  localparam logic [7:0] ACK_CODE_RST      = 8'd14;
  localparam logic [7:0] NAK_CODE_RST      = 8'd15;
  localparam logic [7:0] RETRY_LIMIT_RST   = 8'd8;
  localparam logic [7:0] TIMEOUT_TICKS_RST = 8'd100;

  localparam logic [1:0] CFG_ACK_CODE      = 2'd0;
  localparam logic [1:0] CFG_NAK_CODE      = 2'd1;
  localparam logic [1:0] CFG_RETRY_LIMIT   = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd3;

  localparam logic [1:0] OP_ISSUE = 2'd0;
  localparam logic [1:0] OP_RX    = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] STAT_ACK  = 2'd0;
  localparam logic [1:0] STAT_FAIL = 2'd1;
  localparam logic [1:0] STAT_BUSY = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] cmd_first;
    logic [7:0] cmd_second;
    logic [7:0] cmd_third;
    logic [7:0] cmd_fourth;
    logic [7:0] cmd_fifth;
    logic [7:0] rx_data;
  } in_item_t;

  typedef struct packed {
    logic              result_kind;
    logic [7:0]        tx_data;
    logic [1:0]        status;
    logic [FILL_W-1:0] reply_count;
    logic              last;
  } out_item_t;

  // One job: optional frame, then optional status.
  typedef struct packed {
    logic              has_frame;
    logic              has_status;
    logic [1:0]        status;
    logic [FILL_W-1:0] count;
    logic [7:0]        cmd;
    logic [31:0]       payload;
  } job_t;

endpackage

// ===== design/uce_ctrl.sv =====
module uce_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_wdata,
  input  logic               go,
  input  uce_pkg::in_item_t  item,
  output logic               job_valid,
  output uce_pkg::job_t      job
);

  logic [7:0] ack_code_r, nak_code_r, retry_limit_r, timeout_ticks_r;

  logic [7:0]                 store_r [uce_pkg::REPLY_DEPTH];
  logic [uce_pkg::FILL_W-1:0] fill_r, fill_nxt;
  logic [7:0]                 pending_r, pending_nxt;
  logic [31:0]                payload_r, payload_nxt;
  logic                       waiting_r, waiting_nxt;
  logic [7:0]                 tries_r, tries_nxt;
  logic [7:0]                 ticks_r, ticks_nxt;

  logic       store_we;
  logic [7:0] ticks_per_try;

  assign ticks_per_try = (timeout_ticks_r == 8'd0) ? 8'd1 : timeout_ticks_r;

  always_comb begin
    fill_nxt    = fill_r;
    pending_nxt = pending_r;
    payload_nxt = payload_r;
    waiting_nxt = waiting_r;
    tries_nxt   = tries_r;
    ticks_nxt   = ticks_r;
    store_we    = 1'b0;
    job_valid   = 1'b0;
    job         = '0;
    job.count   = fill_r;
    job.cmd     = pending_r;
    job.payload = payload_r;
    if (go) begin
      unique case (item.opcode)
        uce_pkg::OP_ISSUE: begin
          job_valid = 1'b1;
          if (waiting_r) begin
            job.has_status = 1'b1;
            job.status     = uce_pkg::STAT_BUSY;
          end else begin
            pending_nxt = item.cmd_first;
            payload_nxt = {item.cmd_second, item.cmd_third, item.cmd_fourth, item.cmd_fifth};
            fill_nxt    = '0;
            job.has_frame = 1'b1;
            job.count     = '0;
            job.cmd       = item.cmd_first;
            job.payload   = payload_nxt;
            if (item.cmd_first == ack_code_r || item.cmd_first == nak_code_r) begin
              job.has_status = 1'b1;
              job.status     = uce_pkg::STAT_ACK;
            end else begin
              waiting_nxt = 1'b1;
              tries_nxt   = (retry_limit_r == 8'd0) ? 8'd0 : retry_limit_r - 8'd1;
              ticks_nxt   = ticks_per_try;
            end
          end
        end
        uce_pkg::OP_RX: begin
          if (fill_r < uce_pkg::FILL_W'(uce_pkg::REPLY_DEPTH)) begin
            store_we = 1'b1;
            fill_nxt = fill_r + uce_pkg::FILL_W'(1);
          end
        end
        uce_pkg::OP_TICK: begin
          if (waiting_r) begin
            if (fill_r >= uce_pkg::REPLY_NEEDED &&
                store_r[3] == ack_code_r && store_r[4] == pending_r) begin
              waiting_nxt    = 1'b0;
              job_valid      = 1'b1;
              job.has_status = 1'b1;
              job.status     = uce_pkg::STAT_ACK;
            end else if (fill_r < uce_pkg::REPLY_NEEDED && ticks_r > 8'd1) begin
              ticks_nxt = ticks_r - 8'd1;
            end else begin
              if (fill_r < uce_pkg::REPLY_NEEDED) begin
                ticks_nxt = 8'd0;
              end
              job_valid = 1'b1;
              if (tries_r == 8'd0) begin
                waiting_nxt    = 1'b0;
                job.has_status = 1'b1;
                job.status     = uce_pkg::STAT_FAIL;
              end else begin
                tries_nxt     = tries_r - 8'd1;
                ticks_nxt     = ticks_per_try;
                fill_nxt      = '0;
                job.has_frame = 1'b1;
                job.count     = '0;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_code_r      <= uce_pkg::ACK_CODE_RST;
      nak_code_r      <= uce_pkg::NAK_CODE_RST;
      retry_limit_r   <= uce_pkg::RETRY_LIMIT_RST;
      timeout_ticks_r <= uce_pkg::TIMEOUT_TICKS_RST;
      fill_r          <= '0;
      pending_r       <= '0;
      payload_r       <= '0;
      waiting_r       <= 1'b0;
      tries_r         <= '0;
      ticks_r         <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          uce_pkg::CFG_ACK_CODE:      ack_code_r      <= cfg_wdata;
          uce_pkg::CFG_NAK_CODE:      nak_code_r      <= cfg_wdata;
          uce_pkg::CFG_RETRY_LIMIT:   retry_limit_r   <= cfg_wdata;
          uce_pkg::CFG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      fill_r    <= fill_nxt;
      pending_r <= pending_nxt;
      payload_r <= payload_nxt;
      waiting_r <= waiting_nxt;
      tries_r   <= tries_nxt;
      ticks_r   <= ticks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[fill_r[uce_pkg::STORE_AW-1:0]] <= item.rx_data;
    end
  end

endmodule

// ===== design/uce_emit.sv =====
module uce_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  uce_pkg::job_t      job,
  output logic               slot_free,
  output logic               out_valid,
  input  logic               out_ready,
  output uce_pkg::out_item_t out_item
);

  uce_pkg::job_t             job_r;
  logic                      job_valid_r;
  logic [uce_pkg::IDX_W-1:0] idx_r;
  logic                      out_valid_r;
  uce_pkg::out_item_t        out_r;

  uce_pkg::out_item_t cur;
  logic               in_frame;
  logic               advance;

  assign in_frame = job_r.has_frame && (idx_r < uce_pkg::IDX_W'(uce_pkg::FRAME_LEN));

  always_comb begin
    cur = '0;
    if (in_frame) begin
      cur.result_kind = uce_pkg::KIND_TX;
      unique case (idx_r)
        uce_pkg::IDX_W'(3): cur.tx_data = job_r.cmd;
        uce_pkg::IDX_W'(4): cur.tx_data = job_r.payload[31:24];
        uce_pkg::IDX_W'(5): cur.tx_data = job_r.payload[23:16];
        uce_pkg::IDX_W'(6): cur.tx_data = job_r.payload[15:8];
        uce_pkg::IDX_W'(7): cur.tx_data = job_r.payload[7:0];
        default:            cur.tx_data = uce_pkg::SYNC_BYTE;
      endcase
      cur.last = !job_r.has_status &&
                 (idx_r == uce_pkg::IDX_W'(uce_pkg::FRAME_LEN - 1));
    end else begin
      cur.result_kind = uce_pkg::KIND_STATUS;
      cur.status      = job_r.status;
      cur.last        = 1'b1;
    end
    cur.reply_count = job_r.count;
  end

  assign advance   = job_valid_r && (!out_valid_r || out_ready);
  assign slot_free = !job_valid_r || (advance && cur.last);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (load) begin
        job_valid_r <= 1'b1;
        idx_r       <= '0;
      end else if (advance) begin
        if (cur.last) begin
          job_valid_r <= 1'b0;
          idx_r       <= '0;
        end else begin
          idx_r <= idx_r + uce_pkg::IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= cur;
    end
    if (load) begin
      job_r <= job;
    end
  end

endmodule

// ===== design/uart_command_ack_engine.sv =====
// Command/acknowledge engine for a serial camera link.
// Input channel (in_valid/in_ready/in_item): issue a command, deliver a
// received byte, or a time tick. Result channel (out_valid/out_ready/
// out_item): bytes to transmit and command status, last marks the final
// result of an item. Configuration writes (cfg_we/cfg_index/cfg_wdata) set
// ack code, nak code, retry limit and timeout ticks; write only when idle.
// An item is held in the input register, is decoded against the engine
// state into a job in the job register, and the job is played out one
// result per cycle while out_ready allows, through the output register.
// An item makes 0, 1, 8 or 9 results and holds the job slot until its last
// result enters the output register: 9 results for an issue that finishes
// at once (frame plus status), 8 for a frame alone.
// Reset (synchronous, rst_n low) restores the default register values,
// clears the reply count and returns the engine to idle.
// When out_ready is low the output register holds its item, the job slot
// stays busy and in_ready drops once the input register is full.
module uart_command_ack_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  uce_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output uce_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_wdata
);

  logic              in_valid_r;
  uce_pkg::in_item_t in_item_r;
  logic              slot_free;
  logic              go;
  logic              job_valid;
  uce_pkg::job_t     job;

  assign go       = in_valid_r && slot_free;
  assign in_ready = !in_valid_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_item;
    end
  end

  uce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .go        (go),
    .item      (in_item_r),
    .job_valid (job_valid),
    .job       (job)
  );

  uce_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (job_valid),
    .job       (job),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ===== bench/uart_command_ack_engine_test.sv =====
`timescale 1ns / 100ps

module uart_command_ack_engine_test;
  import uce_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         SETTLE_CYCLES = 16;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;
  logic      cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;

  uart_command_ack_engine uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Register copies and engine state used for prediction.
  logic [7:0]  set_ack;
  logic [7:0]  set_nak;
  logic [7:0]  set_retries;
  logic [7:0]  set_timeout;
  logic [7:0]  eng_store [REPLY_DEPTH];
  int          eng_fill;
  logic [7:0]  eng_cmd;
  logic [31:0] eng_payload;
  bit          eng_waiting;
  logic [7:0]  eng_tries;
  logic [7:0]  eng_ticks;

  out_item_t link_results_due[$];

  int  error_count;
  int  useful_items;
  int  cycle_count;
  int  burst_left;
  int  gap_max;
  bit  hold_request;

  function automatic void push_result(logic kind, logic [7:0] tx, logic [1:0] st,
                                      logic lst);
    out_item_t r;
    r.result_kind = kind;
    r.tx_data     = tx;
    r.status      = st;
    r.reply_count = FILL_W'(eng_fill);
    r.last        = lst;
    link_results_due.push_back(r);
  endfunction

  function automatic void push_frame(bit mark_last);
    logic [7:0] frame [8];
    eng_fill = 0;
    frame = '{SYNC_BYTE, SYNC_BYTE, SYNC_BYTE, eng_cmd, eng_payload[31:24],
              eng_payload[23:16], eng_payload[15:8], eng_payload[7:0]};
    foreach (frame[i])
      push_result(KIND_TX, frame[i], '0, mark_last && i == 7);
  endfunction

  function automatic void retry_or_fail();
    if (eng_tries == 0) begin
      eng_waiting = 1'b0;
      push_result(KIND_STATUS, '0, STAT_FAIL, 1'b1);
    end else begin
      eng_tries--;
      eng_ticks = (set_timeout == 0) ? 8'd1 : set_timeout;
      push_frame(1'b1);
    end
  endfunction

  // Returns 0 when the engine ignores the item.
  function automatic bit step_link_engine(in_item_t it);
    case (it.opcode)
      OP_ISSUE: begin
        if (eng_waiting) begin
          push_result(KIND_STATUS, '0, STAT_BUSY, 1'b1);
        end else begin
          eng_cmd     = it.cmd_first;
          eng_payload = {it.cmd_second, it.cmd_third, it.cmd_fourth, it.cmd_fifth};
          if (it.cmd_first == set_ack || it.cmd_first == set_nak) begin
            push_frame(1'b0);
            push_result(KIND_STATUS, '0, STAT_ACK, 1'b1);
          end else begin
            eng_waiting = 1'b1;
            eng_tries   = (set_retries == 0) ? 8'd0 : set_retries - 8'd1;
            eng_ticks   = (set_timeout == 0) ? 8'd1 : set_timeout;
            push_frame(1'b1);
          end
        end
        return 1'b1;
      end
      OP_RX: begin
        if (eng_fill < REPLY_DEPTH) begin
          eng_store[eng_fill] = it.rx_data;
          eng_fill++;
        end
        return 1'b1;
      end
      OP_TICK: begin
        if (!eng_waiting)
          return 1'b0;
        if (eng_fill >= REPLY_NEEDED) begin
          if (eng_store[3] == set_ack && eng_store[4] == eng_cmd) begin
            eng_waiting = 1'b0;
            push_result(KIND_STATUS, '0, STAT_ACK, 1'b1);
          end else begin
            retry_or_fail();
          end
        end else if (eng_ticks > 1) begin
          eng_ticks--;
        end else begin
          eng_ticks = '0;
          retry_or_fail();
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic in_item_t make_item(logic [1:0] op, logic [7:0] first,
                                         logic [7:0] rx);
    in_item_t it;
    it.opcode     = op;
    it.cmd_first  = first;
    it.cmd_second = 8'($urandom);
    it.cmd_third  = 8'($urandom);
    it.cmd_fourth = 8'($urandom);
    it.cmd_fifth  = 8'($urandom);
    it.rx_data    = rx;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    if (step_link_engine(it))
      useful_items++;
  endtask

  task automatic send_tick();
    send_item(make_item(OP_TICK, 8'($urandom), 8'($urandom)));
  endtask

  // Reply bytes; positions 3 and 4 of the reply get the given values.
  task automatic send_reply(input int count, input logic [7:0] at3, input logic [7:0] at4);
    logic [7:0] b;
    repeat (count) begin
      b = (eng_fill == 3) ? at3 : (eng_fill == 4) ? at4 : 8'($urandom);
      send_item(make_item(OP_RX, 8'($urandom), b));
    end
  endtask

  task automatic close_open_command();
    while (eng_waiting) begin
      if (eng_fill < REPLY_NEEDED)
        send_reply(REPLY_NEEDED - eng_fill, set_ack, eng_cmd);
      else
        send_tick();
    end
  endtask

  task automatic drain_results(input int extra);
    in_valid <= 1'b0;
    while (link_results_due.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] index, input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      CFG_ACK_CODE:      set_ack     = value;
      CFG_NAK_CODE:      set_nak     = value;
      CFG_RETRY_LIMIT:   set_retries = value;
      CFG_TIMEOUT_TICKS: set_timeout = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    in_item_t it;
    gap_max = 4;
    send_item(make_item(OP_RX, 8'h00, 8'hFF));
    send_tick();
    send_item(make_item(OP_UNUSED, 8'hFF, 8'h00));
    it = make_item(OP_ISSUE, set_ack, 8'h00);
    {it.cmd_second, it.cmd_third, it.cmd_fourth, it.cmd_fifth} = '0;
    send_item(it);
    it = make_item(OP_ISSUE, set_nak, 8'hFF);
    {it.cmd_second, it.cmd_third, it.cmd_fourth, it.cmd_fifth} = '1;
    send_item(it);
    it = make_item(OP_ISSUE, 8'hFF, 8'h00);
    {it.cmd_second, it.cmd_third, it.cmd_fourth, it.cmd_fifth} = 32'h00FF_A55A;
    send_item(it);
    send_tick();
    // overfill the reply store, then a rejected issue shows the saturated count
    send_reply(REPLY_DEPTH + 1, set_ack, 8'hFF);
    send_item(make_item(OP_ISSUE, 8'h00, 8'hFF));
    send_tick();
  endtask

  task automatic test_codes_and_retries(input logic [7:0] ack, input logic [7:0] nak,
                                        input logic [7:0] retries,
                                        input logic [7:0] timeout, input int gap,
                                        input int quota);
    int         target;
    int         pick;
    int         round;
    int         n;
    logic [7:0] first;
    close_open_command();
    drain_results(SETTLE_CYCLES);
    write_register(CFG_ACK_CODE, ack);
    write_register(CFG_NAK_CODE, nak);
    write_register(CFG_RETRY_LIMIT, retries);
    write_register(CFG_TIMEOUT_TICKS, timeout);
    gap_max = gap;
    target  = useful_items + quota;
    while (useful_items < target) begin
      if ($urandom_range(0, 3) == 0) begin
        send_item(make_item(2'($urandom), 8'($urandom), 8'($urandom)));
      end else begin
        first = 8'($urandom);
        pick  = $urandom_range(0, 9);
        if (pick == 0)
          first = set_ack;
        else if (pick == 1)
          first = set_nak;
        send_item(make_item(OP_ISSUE, first, 8'($urandom)));
        for (round = 0; round < 3 && eng_waiting; round++) begin
          pick = $urandom_range(0, 9);
          if ($urandom_range(0, 4) == 0)
            send_tick();
          if (pick < 6) begin
            send_reply((pick == 5) ? $urandom_range(8, 17) : 8, set_ack, eng_cmd);
            send_tick();
          end else if (pick < 8) begin
            if (pick == 6)
              send_reply($urandom_range(8, 12), set_ack ^ 8'($urandom_range(1, 255)),
                         eng_cmd);
            else
              send_reply($urandom_range(8, 12), set_ack,
                         eng_cmd ^ 8'($urandom_range(1, 255)));
            send_tick();
          end else begin
            send_reply($urandom_range(0, 7), 8'($urandom), 8'($urandom));
            if (set_timeout <= 8)
              n = int'(eng_ticks);
            else
              n = $urandom_range(1, 3);
            repeat (n) send_tick();
          end
        end
      end
    end
  endtask

  task automatic test_backpressure();
    close_open_command();
    gap_max = 0;
    hold_request = 1'b1;
    repeat (12) send_item(make_item(OP_ISSUE, set_ack, 8'($urandom)));
    drain_results(0);
    repeat (6) send_item(make_item(OP_ISSUE, set_nak, 8'($urandom)));
  endtask

  // Receiver: changes its stall pattern every so often, and holds off for a
  // long stretch on request.
  initial begin : receiver
    int hold_left;
    int mode;
    int mode_left;
    int beat;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 300;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      beat = (beat + 1) % 7;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (beat >= 3);
        endcase
      end
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (link_results_due.size() == 0) begin
        $display("%0t: result with none expected, got %p", $time, out_item);
        error_count++;
      end else begin
        want = link_results_due.pop_front();
        check_field("result_kind", 8'(want.result_kind), 8'(out_item.result_kind));
        check_field("tx_data", want.tx_data, out_item.tx_data);
        check_field("status", 8'(want.status), 8'(out_item.status));
        check_field("reply_count", 8'(want.reply_count), 8'(out_item.reply_count));
        check_field("last", 8'(want.last), 8'(out_item.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    set_ack     = ACK_CODE_RST;
    set_nak     = NAK_CODE_RST;
    set_retries = RETRY_LIMIT_RST;
    set_timeout = TIMEOUT_TICKS_RST;
    foreach (eng_store[i])
      eng_store[i] = '0;
    eng_fill    = 0;
    eng_cmd     = '0;
    eng_payload = '0;
    eng_waiting = 1'b0;
    eng_tries   = '0;
    eng_ticks   = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_codes_and_retries(ACK_CODE_RST, NAK_CODE_RST, RETRY_LIMIT_RST,
                           TIMEOUT_TICKS_RST, 10, 55);
    test_codes_and_retries(8'h00, 8'hFF, 8'd1, 8'd1, 0, 55);
    test_codes_and_retries(8'hFF, 8'h00, 8'd3, 8'd4, 6, 55);
    test_codes_and_retries(8'($urandom), 8'($urandom), 8'd255, 8'd255, 3, 55);
    test_backpressure();
    close_open_command();
    drain_results(SETTLE_CYCLES);
    if (error_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
